// File: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define FHSS_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// concurrent assertion on clk_i and rst_ni
`define FHSS_ASSERT(lbl, prop) \
  `FHSS_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// File: hdl/fhss_pkg.sv
// types, codes and constants of the floppy head step and seek controller
// no dependencies
`default_nettype none

package fhss_pkg;

  localparam int RateBits    = 16;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;

  // item kinds
  localparam logic [1:0] KindTick  = 2'd0;
  localparam logic [1:0] KindCmd   = 2'd1;
  localparam logic [1:0] KindTrack = 2'd2;
  localparam logic [1:0] KindData  = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgStepRate0   = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgStepRate1   = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgStepRate2   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgStepRate3   = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgMaxCylinder = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgDiskPresent = 3'd5;
  localparam logic [CfgIdxBits-1:0] CfgTracks      = 3'd6;

  // pending operation codes
  localparam logic [2:0] OpNone    = 3'd0;
  localparam logic [2:0] OpRestore = 3'd1;
  localparam logic [2:0] OpSeek    = 3'd2;
  localparam logic [2:0] OpStep    = 3'd3;
  localparam logic [2:0] OpStepIn  = 3'd4;
  localparam logic [2:0] OpStepOut = 3'd5;

  // command prefixes, bits 7..5
  localparam logic [2:0] CmdRestoreSeek = 3'b000;
  localparam logic [2:0] CmdStep        = 3'b001;
  localparam logic [2:0] CmdStepIn      = 3'b010;
  localparam logic [2:0] CmdStepOut     = 3'b011;
  localparam logic [2:0] CmdForceIrq    = 3'b110;

  localparam logic [7:0] StepInLimit = 8'd76;

  typedef struct packed {
    logic [3:0][RateBits-1:0] step_rate;
    logic [7:0]               max_cylinder;
    logic                     disk_present;
    logic [7:0]               tracks_per_side;
  } cfg_t;

  typedef struct packed {
    logic       busy_res;
    logic       seek_error;
    logic [7:0] track_value;
    logic [7:0] head_position;
    logic       finished;
    logic       nmi_request;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/fhss_if.sv
// handshake channels of the floppy head step and seek controller
// depends on fhss_pkg
`default_nettype none

interface fhss_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface fhss_out_if;
  logic       valid;
  logic       ready;
  logic       busy_res;
  logic       seek_error;
  logic [7:0] track_value;
  logic [7:0] head_position;
  logic       finished;
  logic       nmi_request;

  modport source (output valid, output busy_res, output seek_error, output track_value,
                  output head_position, output finished, output nmi_request, input ready);
  modport sink (input valid, input busy_res, input seek_error, input track_value,
                input head_position, input finished, input nmi_request, output ready);
endinterface

interface fhss_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fhss_pkg::CfgIdxBits-1:0]   index;
  logic [fhss_pkg::CfgDataBits-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/fhss_cfg.sv
// configuration registers: step rates, cylinder limit, disk presence, track count
// depends on fhss_pkg
`default_nettype none

module fhss_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             wr_i,
  input  wire logic [fhss_pkg::CfgIdxBits-1:0]  index_i,
  input  wire logic [fhss_pkg::CfgDataBits-1:0] data_i,
  output fhss_pkg::cfg_t                        cfg_o
);

  fhss_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_rate[0]    <= fhss_pkg::RateBits'(6);
      cfg_q.step_rate[1]    <= fhss_pkg::RateBits'(12);
      cfg_q.step_rate[2]    <= fhss_pkg::RateBits'(20);
      cfg_q.step_rate[3]    <= fhss_pkg::RateBits'(30);
      cfg_q.max_cylinder    <= 8'd40;
      cfg_q.disk_present    <= 1'b0;
      cfg_q.tracks_per_side <= 8'd35;
    end else if (wr_i) begin
      unique case (index_i)
        fhss_pkg::CfgStepRate0:   cfg_q.step_rate[0] <= fhss_pkg::RateBits'(data_i);
        fhss_pkg::CfgStepRate1:   cfg_q.step_rate[1] <= fhss_pkg::RateBits'(data_i);
        fhss_pkg::CfgStepRate2:   cfg_q.step_rate[2] <= fhss_pkg::RateBits'(data_i);
        fhss_pkg::CfgStepRate3:   cfg_q.step_rate[3] <= fhss_pkg::RateBits'(data_i);
        fhss_pkg::CfgMaxCylinder: cfg_q.max_cylinder <= data_i[7:0];
        fhss_pkg::CfgDiskPresent: cfg_q.disk_present <= data_i[0];
        fhss_pkg::CfgTracks:      cfg_q.tracks_per_side <= data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hdl/fhss_core.sv
// controller state and its per-item update: ticks, commands, register writes
// depends on fhss_pkg
`default_nettype none

module fhss_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] value_i,
  input  wire fhss_pkg::cfg_t cfg_i,
  output fhss_pkg::result_t res_o
);

  logic [2:0]                  op_q, op_d;
  logic [fhss_pkg::RateBits-1:0] wait_q, wait_d;
  logic [fhss_pkg::RateBits-1:0] rate_q, rate_d;
  logic [fhss_pkg::RateBits-1:0] wait_dec;
  logic [fhss_pkg::RateBits-1:0] sel_rate;
  logic [7:0] head_q, head_d;
  logic [7:0] track_q, track_d;
  logic [7:0] data_q, data_d;
  logic [7:0] target_q, target_d;
  logic       inward_q, inward_d;
  logic       verify_q, verify_d;
  logic       update_q, update_d;
  logic       busy_q, busy_d;
  logic       serr_q, serr_d;
  logic       done;
  logic       nmi;

  assign wait_dec = wait_q - fhss_pkg::RateBits'(1);
  assign sel_rate = cfg_i.step_rate[value_i[1:0]];

  always_comb begin
    op_d     = op_q;
    wait_d   = wait_q;
    rate_d   = rate_q;
    head_d   = head_q;
    track_d  = track_q;
    data_d   = data_q;
    target_d = target_q;
    inward_d = inward_q;
    verify_d = verify_q;
    update_d = update_q;
    busy_d   = busy_q;
    serr_d   = serr_q;
    done     = 1'b0;
    nmi      = 1'b0;
    if (en_i) begin
      unique case (kind_i)
        fhss_pkg::KindTick: begin
          if (op_q != fhss_pkg::OpNone && op_q <= fhss_pkg::OpStepOut) begin
            wait_d = wait_dec;
            if (wait_dec == '0) begin
              case (op_q)
                fhss_pkg::OpRestore: begin
                  if (head_q == 8'd0) begin
                    track_d = 8'd0;
                    op_d    = fhss_pkg::OpNone;
                    busy_d  = 1'b0;
                    serr_d  = 1'b0;
                    done    = 1'b1;
                  end else begin
                    head_d   = head_q - 8'd1;
                    inward_d = 1'b0;
                    wait_d   = rate_q;
                  end
                end
                fhss_pkg::OpSeek: begin
                  if (head_q == target_q) begin
                    op_d   = fhss_pkg::OpNone;
                    busy_d = 1'b0;
                    serr_d = verify_q &&
                             (!cfg_i.disk_present || head_q > cfg_i.tracks_per_side);
                    done   = 1'b1;
                  end else begin
                    if (head_q > target_q) begin
                      head_d   = head_q - 8'd1;
                      track_d  = track_q - 8'd1;
                      inward_d = 1'b0;
                    end else begin
                      if (head_q < cfg_i.max_cylinder) begin
                        head_d  = head_q + 8'd1;
                        track_d = track_q + 8'd1;
                      end
                      inward_d = 1'b1;
                    end
                    wait_d = rate_q;
                  end
                end
                fhss_pkg::OpStep: begin
                  if (!inward_q) begin
                    if (head_q > 8'd0) head_d = head_q - 8'd1;
                    if (update_q && track_q > 8'd0) track_d = track_q - 8'd1;
                  end else begin
                    if (head_q < cfg_i.max_cylinder) head_d = head_q + 8'd1;
                    if (update_q && track_q < cfg_i.max_cylinder) track_d = track_q + 8'd1;
                  end
                  op_d   = fhss_pkg::OpNone;
                  busy_d = 1'b0;
                  done   = 1'b1;
                end
                fhss_pkg::OpStepIn: begin
                  if (head_q < fhss_pkg::StepInLimit) begin
                    head_d   = head_q + 8'd1;
                    inward_d = 1'b1;
                  end
                  if (update_q && track_q < cfg_i.max_cylinder) track_d = track_q + 8'd1;
                  op_d   = fhss_pkg::OpNone;
                  busy_d = 1'b0;
                  done   = 1'b1;
                end
                default: begin
                  if (head_q > 8'd0) begin
                    head_d   = head_q - 8'd1;
                    inward_d = 1'b0;
                  end
                  if (update_q && track_q > 8'd0) track_d = track_q - 8'd1;
                  op_d   = fhss_pkg::OpNone;
                  busy_d = 1'b0;
                  done   = 1'b1;
                end
              endcase
            end
          end
        end
        fhss_pkg::KindCmd: begin
          unique case (value_i[7:5])
            fhss_pkg::CmdRestoreSeek, fhss_pkg::CmdStep, fhss_pkg::CmdStepIn,
            fhss_pkg::CmdStepOut: begin
              rate_d   = sel_rate;
              wait_d   = sel_rate;
              verify_d = value_i[2];
              busy_d   = 1'b1;
              serr_d   = 1'b0;
              if (value_i[7:5] == fhss_pkg::CmdRestoreSeek) begin
                head_d = track_q;
                if (value_i[4]) begin
                  target_d = data_q;
                  op_d     = fhss_pkg::OpSeek;
                end else begin
                  op_d = fhss_pkg::OpRestore;
                end
              end else begin
                update_d = value_i[4];
                op_d     = fhss_pkg::OpStep + (value_i[7:5] - fhss_pkg::CmdStep);
              end
            end
            fhss_pkg::CmdForceIrq: begin
              if (value_i[4]) begin
                op_d   = fhss_pkg::OpNone;
                busy_d = 1'b0;
                nmi    = value_i[3];
              end
            end
            default: ;
          endcase
        end
        fhss_pkg::KindTrack: track_d = value_i;
        default:             data_d  = value_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= fhss_pkg::OpNone;
      wait_q   <= '0;
      rate_q   <= '0;
      head_q   <= 8'd0;
      track_q  <= 8'd0;
      data_q   <= 8'd0;
      target_q <= 8'd0;
      inward_q <= 1'b0;
      verify_q <= 1'b0;
      update_q <= 1'b0;
      busy_q   <= 1'b0;
      serr_q   <= 1'b0;
    end else begin
      op_q     <= op_d;
      wait_q   <= wait_d;
      rate_q   <= rate_d;
      head_q   <= head_d;
      track_q  <= track_d;
      data_q   <= data_d;
      target_q <= target_d;
      inward_q <= inward_d;
      verify_q <= verify_d;
      update_q <= update_d;
      busy_q   <= busy_d;
      serr_q   <= serr_d;
    end
  end

  assign res_o.busy_res      = busy_d;
  assign res_o.seek_error    = serr_d;
  assign res_o.track_value   = track_d;
  assign res_o.head_position = head_d;
  assign res_o.finished      = done;
  assign res_o.nmi_request   = nmi;

endmodule

`default_nettype wire

// File: hdl/floppy_head_step_seek_controller.sv
// top level of the floppy head step and seek controller
// depends on fhss_pkg, fhss_if, fhss_cfg and fhss_core
//
// usage
//   in_i carries one item per handshake: kind (tick, command write, track
//   register write, data register write) and the byte written. out_o returns
//   exactly one result item per input item, in order: busy, seek error, track
//   register, head cylinder, finished and nmi request. cfg_i writes the step
//   rates, the cylinder limit, disk presence and the track count; it is always
//   ready. Users must write it only while the block is idle; it is not enforced.
// timing
//   an accepted item lands in an input register, is processed once the result
//   register can accept it, and its result is registered. one item per cycle is
//   sustained while out_o is ready; the state update is a single pass of compares
//   and increments between the input and result registers.
// reset and stall
//   reset empties both registers and loads the state and the configuration
//   with their initial values. while out_o stalls, the result register holds
//   its item and one more item waits in the input register before in_i
//   drops ready.
`default_nettype none

module floppy_head_step_seek_controller (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fhss_in_if.sink     in_i,
  fhss_out_if.source  out_o,
  fhss_cfg_if.sink    cfg_i
);

  logic              in_valid_q;
  logic [1:0]        kind_q;
  logic [7:0]        value_q;
  logic              out_valid_q;
  fhss_pkg::result_t res_q;
  fhss_pkg::result_t res;
  fhss_pkg::cfg_t    cfg;
  logic              advance;
  logic              proc;

  assign advance = !out_valid_q || out_o.ready;
  assign proc    = in_valid_q && advance;

  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  fhss_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_i.valid),
    .index_i (cfg_i.index),
    .data_i  (cfg_i.data),
    .cfg_o   (cfg)
  );

  fhss_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (proc),
    .kind_i  (kind_q),
    .value_i (value_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q  <= in_i.kind;
      value_q <= in_i.value;
    end
    if (proc) res_q <= res;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.busy_res      = res_q.busy_res;
  assign out_o.seek_error    = res_q.seek_error;
  assign out_o.track_value   = res_q.track_value;
  assign out_o.head_position = res_q.head_position;
  assign out_o.finished      = res_q.finished;
  assign out_o.nmi_request   = res_q.nmi_request;

endmodule

`default_nettype wire

// File: hdl/fhss_checker.sv
// port-level assertions for the floppy head step and seek controller, with bind
// depends on assert_macros.svh and floppy_head_step_seek_controller
`default_nettype none
`include "assert_macros.svh"

module fhss_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       busy_i,
  input wire logic       finished_i,
  input wire logic       nmi_i,
  input wire logic [7:0] track_i
);

  `FHSS_ASSERT(a_stall_holds, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(track_i)))
  `FHSS_ASSERT(a_ready_only_on_stall, !in_ready_i |-> (out_valid_i && !out_ready_i))
  `FHSS_ASSERT(a_finished_not_busy, (out_valid_i && finished_i) |-> !busy_i)
  `FHSS_ASSERT(a_nmi_alone, (out_valid_i && nmi_i) |-> (!busy_i && !finished_i))

endmodule

bind floppy_head_step_seek_controller fhss_checker u_fhss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .busy_i      (out_o.busy_res),
  .finished_i  (out_o.finished),
  .nmi_i       (out_o.nmi_request),
  .track_i     (out_o.track_value)
);

`default_nettype wire
